FILE: rtl/core/socks5_udp_header_deframer_macros.svh
// Assertion macros shared by the deframer's RTL files.
`ifndef SOCKS5_UDP_HEADER_DEFRAMER_MACROS_SVH
`define SOCKS5_UDP_HEADER_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SUDP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define SUDP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SUDP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SUDP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/sudp_pkg.sv
// Package with the deframer's types, codes and constants.
package sudp_pkg;

  // Default size of the receive buffer in bytes.
  localparam int unsigned MAX_DATAGRAM_DEF = 65536;
  // Datagrams shorter than this are reported as short.
  localparam int unsigned MIN_DATAGRAM = 10;

  // Depth of the queue between parser and output stage.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_LINK_CONNECTED = 1'b0;
  localparam logic CFG_BUFFER_CAPACITY = 1'b1;

  // Address type codes on the wire.
  localparam logic [7:0] ATYP_IPV4 = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6 = 8'h04;
  localparam logic [7:0] FRAG_NONE = 8'h00;

  // Address lengths for the fixed-size types.
  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  // Position within the datagram header.
  typedef enum logic [3:0] {
    PH_RSV1,
    PH_RSV2,
    PH_FRAG,
    PH_ATYP,
    PH_DLEN,
    PH_ADDR,
    PH_PHI,
    PH_PLO,
    PH_PAY
  } phase_t;

  // Datagram completion status.
  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_CONN,
    ST_SHORT,
    ST_FRAG,
    ST_BAD_ATYP,
    ST_TRUNC
  } status_t;

  // Kind of source address.
  typedef enum logic [1:0] {
    AK_IPV4,
    AK_DOMAIN,
    AK_IPV6,
    AK_UNKNOWN
  } addr_kind_t;

  // Kind of byte passed through.
  typedef enum logic {
    BK_ADDR,
    BK_PAY
  } byte_kind_t;

  // One result request as it travels from parser to output.
  typedef struct packed {
    logic       has_byte;
    byte_kind_t byte_kind;
    logic [7:0] out_byte;
    addr_kind_t addr_kind;
    logic [15:0] source_port;
    status_t    status;
    logic [15:0] copied_length;
    logic       last;
  } rec_t;

endpackage

FILE: rtl/core/sudp_front.sv
// Parser front end: takes bytes, tracks the header and builds result requests.
`include "socks5_udp_header_deframer_macros.svh"

module sudp_front #(
  parameter int unsigned MAX_DATAGRAM = sudp_pkg::MAX_DATAGRAM_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_datagram,
  output logic             push,
  output sudp_pkg::rec_t   push_rec
);

  localparam int unsigned CNT_W = $clog2(MAX_DATAGRAM + 1);

  // Configuration registers.
  logic        link_connected;
  logic [15:0] buffer_capacity;

  // Per-datagram state.
  sudp_pkg::phase_t     phase, phase_next, phase_upd;
  logic [CNT_W-1:0]     byte_count, byte_count_next, byte_count_upd;
  logic [7:0]           addr_remaining, addr_remaining_next, addr_remaining_upd;
  logic [7:0]           rem_dec;
  sudp_pkg::addr_kind_t addr_type, addr_type_next, addr_type_upd;
  logic [15:0]          port_shift, port_shift_next, port_shift_upd;
  logic [15:0]          copied_count, copied_count_next, copied_count_upd;
  sudp_pkg::status_t    error_code, error_code_next, error_code_upd;

  logic                 emit;
  sudp_pkg::byte_kind_t kind;
  sudp_pkg::status_t    status_v;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_connected  <= 1'b0;
      buffer_capacity <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        sudp_pkg::CFG_LINK_CONNECTED:  link_connected  <= cfg_data[0];
        sudp_pkg::CFG_BUFFER_CAPACITY: buffer_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Header walk for one byte.
  always_comb begin
    phase_upd          = phase;
    addr_remaining_upd = addr_remaining;
    addr_type_upd      = addr_type;
    port_shift_upd     = port_shift;
    copied_count_upd   = copied_count;
    error_code_upd     = error_code;
    emit               = 1'b0;
    kind               = sudp_pkg::BK_ADDR;
    rem_dec            = (addr_remaining != 8'd0) ? addr_remaining - 8'd1 : addr_remaining;

    if (!link_connected) begin
      error_code_upd = sudp_pkg::ST_NOT_CONN;
    end else if (byte_count >= CNT_W'(MAX_DATAGRAM)) begin
      // Past the receive buffer: the byte is ignored.
    end else if (error_code == sudp_pkg::ST_OK) begin
      unique case (phase)
        sudp_pkg::PH_RSV1: phase_upd = sudp_pkg::PH_RSV2;
        sudp_pkg::PH_RSV2: phase_upd = sudp_pkg::PH_FRAG;
        sudp_pkg::PH_FRAG: begin
          if (rx_byte != sudp_pkg::FRAG_NONE) error_code_upd = sudp_pkg::ST_FRAG;
          else phase_upd = sudp_pkg::PH_ATYP;
        end
        sudp_pkg::PH_ATYP: begin
          if (rx_byte == sudp_pkg::ATYP_IPV4) begin
            addr_type_upd      = sudp_pkg::AK_IPV4;
            addr_remaining_upd = sudp_pkg::IPV4_LEN;
            phase_upd          = sudp_pkg::PH_ADDR;
          end else if (rx_byte == sudp_pkg::ATYP_DOMAIN) begin
            addr_type_upd = sudp_pkg::AK_DOMAIN;
            phase_upd     = sudp_pkg::PH_DLEN;
          end else if (rx_byte == sudp_pkg::ATYP_IPV6) begin
            addr_type_upd      = sudp_pkg::AK_IPV6;
            addr_remaining_upd = sudp_pkg::IPV6_LEN;
            phase_upd          = sudp_pkg::PH_ADDR;
          end else begin
            addr_type_upd  = sudp_pkg::AK_UNKNOWN;
            error_code_upd = sudp_pkg::ST_BAD_ATYP;
          end
        end
        sudp_pkg::PH_DLEN: begin
          addr_remaining_upd = rx_byte;
          phase_upd = (rx_byte == 8'd0) ? sudp_pkg::PH_PHI : sudp_pkg::PH_ADDR;
        end
        sudp_pkg::PH_ADDR: begin
          emit               = 1'b1;
          kind               = sudp_pkg::BK_ADDR;
          addr_remaining_upd = rem_dec;
          if (rem_dec == 8'd0) phase_upd = sudp_pkg::PH_PHI;
        end
        sudp_pkg::PH_PHI: begin
          port_shift_upd = {rx_byte, 8'h00};
          phase_upd      = sudp_pkg::PH_PLO;
        end
        sudp_pkg::PH_PLO: begin
          port_shift_upd = port_shift | {8'h00, rx_byte};
          phase_upd      = sudp_pkg::PH_PAY;
        end
        sudp_pkg::PH_PAY: begin
          if (copied_count < buffer_capacity) begin
            emit             = 1'b1;
            kind             = sudp_pkg::BK_PAY;
            copied_count_upd = copied_count + 16'd1;
          end
        end
        default: ;
      endcase
    end

    byte_count_upd = (&byte_count) ? byte_count : byte_count + CNT_W'(1);

    // Final status, ranked by priority.
    if (error_code_upd == sudp_pkg::ST_NOT_CONN) status_v = sudp_pkg::ST_NOT_CONN;
    else if (byte_count_upd < CNT_W'(sudp_pkg::MIN_DATAGRAM)) status_v = sudp_pkg::ST_SHORT;
    else if (error_code_upd != sudp_pkg::ST_OK) status_v = error_code_upd;
    else if (phase_upd != sudp_pkg::PH_PAY) status_v = sudp_pkg::ST_TRUNC;
    else status_v = sudp_pkg::ST_OK;
  end

  // Result request and next state; the final byte returns the per-datagram state to reset.
  always_comb begin
    push                   = accept && (emit || end_of_datagram);
    push_rec.has_byte      = emit;
    push_rec.byte_kind     = emit ? kind : sudp_pkg::BK_ADDR;
    push_rec.out_byte      = emit ? rx_byte : 8'h00;
    push_rec.addr_kind     = addr_type_upd;
    push_rec.last          = end_of_datagram;
    push_rec.status        = end_of_datagram ? status_v : sudp_pkg::ST_OK;
    push_rec.source_port   = (end_of_datagram && status_v == sudp_pkg::ST_OK) ?
                             port_shift_upd : 16'h0000;
    push_rec.copied_length = (end_of_datagram && status_v == sudp_pkg::ST_OK) ?
                             copied_count_upd : 16'h0000;

    phase_next          = phase;
    byte_count_next     = byte_count;
    addr_remaining_next = addr_remaining;
    addr_type_next      = addr_type;
    port_shift_next     = port_shift;
    copied_count_next   = copied_count;
    error_code_next     = error_code;
    if (accept) begin
      if (end_of_datagram) begin
        phase_next          = sudp_pkg::PH_RSV1;
        byte_count_next     = '0;
        addr_remaining_next = 8'd0;
        addr_type_next      = sudp_pkg::AK_UNKNOWN;
        port_shift_next     = 16'h0000;
        copied_count_next   = 16'h0000;
        error_code_next     = sudp_pkg::ST_OK;
      end else begin
        phase_next          = phase_upd;
        byte_count_next     = byte_count_upd;
        addr_remaining_next = addr_remaining_upd;
        addr_type_next      = addr_type_upd;
        port_shift_next     = port_shift_upd;
        copied_count_next   = copied_count_upd;
        error_code_next     = error_code_upd;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sudp_pkg::PH_RSV1;
      byte_count     <= '0;
      addr_remaining <= 8'd0;
      addr_type      <= sudp_pkg::AK_UNKNOWN;
      port_shift     <= 16'h0000;
      copied_count   <= 16'h0000;
      error_code     <= sudp_pkg::ST_OK;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      addr_remaining <= addr_remaining_next;
      addr_type      <= addr_type_next;
      port_shift     <= port_shift_next;
      copied_count   <= copied_count_next;
      error_code     <= error_code_next;
    end
  end

  // A final byte leaves the parser back at the start of a datagram.
  `SUDP_ASSERT_NXT(a_front_clear, clk, rst, push && push_rec.last,
                   phase == sudp_pkg::PH_RSV1 && byte_count == '0)
  // Failed datagrams report no payload length and no port.
  `SUDP_ASSERT_IMP(a_front_err_zero, clk, rst,
                   push && push_rec.status != sudp_pkg::ST_OK,
                   push_rec.copied_length == 16'h0000 && push_rec.source_port == 16'h0000)

endmodule

FILE: rtl/core/sudp_queue.sv
// Short queue of result requests between the parser and the output stage.
`include "socks5_udp_header_deframer_macros.svh"

module sudp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sudp_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output sudp_pkg::rec_t head
);

  sudp_pkg::rec_t                 entries [sudp_pkg::QUEUE_DEPTH];
  logic [sudp_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [sudp_pkg::QCNT_W-1:0]    count;

  assign full      = (count == sudp_pkg::QCNT_W'(sudp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + sudp_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + sudp_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + sudp_pkg::QCNT_W'(1);
        2'b01:   count <= count - sudp_pkg::QCNT_W'(1);
        default: ;
      endcase
    end
  end

  // The parser must never write into a full queue.
  `SUDP_ASSERT_IMP(a_queue_no_overflow, clk, rst, push, !full)
  // The output stage must never take from an empty queue.
  `SUDP_ASSERT_IMP(a_queue_no_underflow, clk, rst, pop, not_empty)

endmodule

FILE: rtl/core/sudp_back.sv
// Output stage: takes requests from the queue into the output register.
module sudp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           not_empty,
  input  sudp_pkg::rec_t head,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output sudp_pkg::rec_t out_rec
);

  logic out_valid_next;

  // Load when the register is empty or its request is taken this cycle.
  assign pop = not_empty && (!out_valid || !out_stall);

  always_comb begin
    out_valid_next = out_valid;
    if (pop) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= out_valid_next;
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (pop) out_rec <= head;
  end

endmodule

FILE: rtl/core/socks5_udp_header_deframer.sv
// Top level of the SOCKS5 UDP datagram header deframer.
//
//  Channel  Handshake               Carries
//  -------  ----------------------  -----------------------------------------------
//  cfg      cfg_write               cfg_index, cfg_data (link flag, buffer capacity)
//  in       in_valid / in_stall     rx_byte, end_of_datagram
//  out      out_valid / out_stall   has_byte, byte_kind, out_byte, addr_kind,
//                                   source_port, status, copied_length, last
//
// One byte is taken per cycle while in_stall is low; the parser walks the header combinationally.
// A result request reaches the outputs through the queue and then the
// output register.
// The two-entry queue lets the parser keep accepting while the output is stalled;
// in_stall rises only when the queue is full.
// Synchronous reset clears the parser, the queue and the output register; there is
// no clearing pass.
module socks5_udp_header_deframer #(
  parameter int unsigned MAX_DATAGRAM = sudp_pkg::MAX_DATAGRAM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_datagram,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        has_byte,
  output logic        byte_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  addr_kind,
  output logic [15:0] source_port,
  output logic [2:0]  status,
  output logic [15:0] copied_length,
  output logic        last
);

  logic           accept;
  logic           push;
  sudp_pkg::rec_t push_rec;
  logic           q_full;
  logic           q_not_empty;
  sudp_pkg::rec_t q_head;
  logic           pop;
  sudp_pkg::rec_t out_rec;

  // Input requests are taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  sudp_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .accept          (accept),
    .rx_byte         (rx_byte),
    .end_of_datagram (end_of_datagram),
    .push            (push),
    .push_rec        (push_rec)
  );

  sudp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sudp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (q_head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  // Output fields.
  assign has_byte      = out_rec.has_byte;
  assign byte_kind     = out_rec.byte_kind;
  assign out_byte      = out_rec.out_byte;
  assign addr_kind     = out_rec.addr_kind;
  assign source_port   = out_rec.source_port;
  assign status        = out_rec.status;
  assign copied_length = out_rec.copied_length;
  assign last          = out_rec.last;

endmodule

FILE: verif/socks5_udp_header_deframer_tb.sv
// Self-checking testbench for the SOCKS5 UDP datagram header deframer.
`timescale 1ns / 1ps

module socks5_udp_header_deframer_tb;
  import sudp_pkg::*;

  // Tracks the deframer's parse state per accepted byte and holds the expected requests.
  class deframe_tracker;
    bit          link;
    bit [15:0]   cap;
    phase_t      hdr_phase;
    bit [16:0]   count;
    bit [7:0]    addr_left;
    addr_kind_t  akind;
    bit [15:0]   port;
    bit [15:0]   copied;
    status_t     err;
    rec_t        expected_recs[$];
    int          errors;

    function new();
      link = 1'b0;
      cap = 16'hFFFF;
      errors = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      hdr_phase = PH_RSV1;
      count = '0;
      addr_left = '0;
      akind = AK_UNKNOWN;
      port = '0;
      copied = '0;
      err = ST_OK;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == CFG_LINK_CONNECTED) begin
        link = data[0];
      end else begin
        cap = data;
      end
    endfunction

    // Advance the header walk by one byte and queue the request it gives, if any.
    function void note_byte(bit [7:0] b, bit eod);
      bit [16:0]  idx;
      bit         emit;
      byte_kind_t kind;
      status_t    st;
      rec_t       r;
      idx = count;
      emit = 1'b0;
      kind = BK_ADDR;
      if (!link) begin
        err = ST_NOT_CONN;
      end else if (idx >= MAX_DATAGRAM_DEF) begin
        // Past the receive buffer: the byte is dropped silently.
      end else if (err == ST_OK) begin
        case (hdr_phase)
          PH_RSV1: hdr_phase = PH_RSV2;
          PH_RSV2: hdr_phase = PH_FRAG;
          PH_FRAG: begin
            if (b != FRAG_NONE) err = ST_FRAG;
            else hdr_phase = PH_ATYP;
          end
          PH_ATYP: begin
            if (b == ATYP_IPV4) begin
              akind = AK_IPV4;
              addr_left = IPV4_LEN;
              hdr_phase = PH_ADDR;
            end else if (b == ATYP_DOMAIN) begin
              akind = AK_DOMAIN;
              hdr_phase = PH_DLEN;
            end else if (b == ATYP_IPV6) begin
              akind = AK_IPV6;
              addr_left = IPV6_LEN;
              hdr_phase = PH_ADDR;
            end else begin
              akind = AK_UNKNOWN;
              err = ST_BAD_ATYP;
            end
          end
          PH_DLEN: begin
            addr_left = b;
            hdr_phase = (b == 8'd0) ? PH_PHI : PH_ADDR;
          end
          PH_ADDR: begin
            emit = 1'b1;
            kind = BK_ADDR;
            if (addr_left != 0) addr_left--;
            if (addr_left == 0) hdr_phase = PH_PHI;
          end
          PH_PHI: begin
            port = {b, 8'h00};
            hdr_phase = PH_PLO;
          end
          PH_PLO: begin
            port = {port[15:8], b};
            hdr_phase = PH_PAY;
          end
          default: begin
            if (copied < cap) begin
              emit = 1'b1;
              kind = BK_PAY;
              copied++;
            end
          end
        endcase
      end
      count = (idx != 17'h1FFFF) ? idx + 17'd1 : idx;
      if (!emit && !eod) return;

      r = '0;
      r.addr_kind = akind;
      r.byte_kind = BK_ADDR;
      r.status = ST_OK;
      if (emit) begin
        r.has_byte = 1'b1;
        r.byte_kind = kind;
        r.out_byte = b;
      end
      if (eod) begin
        // Not connected outranks a short datagram, which outranks the parse errors.
        if (err == ST_NOT_CONN) st = ST_NOT_CONN;
        else if (count < MIN_DATAGRAM) st = ST_SHORT;
        else if (err != ST_OK) st = err;
        else if (hdr_phase != PH_PAY) st = ST_TRUNC;
        else st = ST_OK;
        r.last = 1'b1;
        r.status = st;
        if (st == ST_OK) begin
          r.source_port = port;
          r.copied_length = copied;
        end
        clear_datagram();
      end
      expected_recs.insert(expected_recs.size(), r);
    endfunction

    function void field_chk(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered request with the oldest one still awaited.
    function void check_rec(rec_t got);
      rec_t want;
      if (expected_recs.size() == 0) begin
        $display("%0t: request expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_recs.pop_front();
      field_chk("has_byte", want.has_byte, got.has_byte);
      field_chk("byte_kind", want.byte_kind, got.byte_kind);
      field_chk("out_byte", want.out_byte, got.out_byte);
      field_chk("addr_kind", want.addr_kind, got.addr_kind);
      field_chk("source_port", want.source_port, got.source_port);
      field_chk("status", want.status, got.status);
      field_chk("copied_length", want.copied_length, got.copied_length);
      field_chk("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_LINK_CONNECTED;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        end_of_datagram = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        has_byte;
  logic        byte_kind;
  logic [7:0]  out_byte;
  logic [1:0]  addr_kind;
  logic [15:0] source_port;
  logic [2:0]  status;
  logic [15:0] copied_length;
  logic        last;

  deframe_tracker tracker;
  bit             idle_on = 1'b1;
  bit [7:0]       dgram[$];

  socks5_udp_header_deframer u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .end_of_datagram(end_of_datagram),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .has_byte(has_byte),
    .byte_kind(byte_kind),
    .out_byte(out_byte),
    .addr_kind(addr_kind),
    .source_port(source_port),
    .status(status),
    .copied_length(copied_length),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls at random unless a quiet stretch is running.
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 32);
  end

  // Outputs and stall are stable at the falling edge; a request taken here moves next edge.
  always @(negedge clk) begin
    rec_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {has_byte, byte_kind, out_byte, addr_kind, source_port, status,
             copied_length, last};
      tracker.check_rec(got);
    end
  end

  task automatic drive_byte(bit [7:0] b, bit eod);
    bit taken;
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    end_of_datagram <= eod;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    tracker.note_byte(b, eod);
  endtask

  task automatic send_dgram();
    for (int i = 0; i < dgram.size(); i++) begin
      drive_byte(dgram[i], i == dgram.size() - 1);
    end
  endtask

  // Hold the sender off until every awaited request has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_recs.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    drain();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  // Add one byte at the end of the datagram being built.
  function automatic void append_byte(bit [7:0] b);
    dgram.insert(dgram.size(), b);
  endfunction

  // Header with random reserved, address and port bytes, then the payload.
  function automatic void build_dgram(bit [7:0] frag, bit [7:0] atyp, int dlen, int plen);
    int alen;
    dgram.delete();
    append_byte(8'($urandom_range(255)));
    append_byte(8'($urandom_range(255)));
    append_byte(frag);
    append_byte(atyp);
    alen = 0;
    if (atyp == ATYP_DOMAIN) begin
      append_byte(8'(dlen));
      alen = dlen;
    end else if (atyp == ATYP_IPV4) begin
      alen = IPV4_LEN;
    end else if (atyp == ATYP_IPV6) begin
      alen = IPV6_LEN;
    end
    repeat (alen + 2 + plen) append_byte(8'($urandom_range(255)));
  endfunction

  function automatic void cut_dgram(int n);
    dgram = dgram[0:n-1];
  endfunction

  // Mostly well-formed datagrams, some cut short, the rest broken or noise.
  task automatic random_dgram();
    int       r;
    int       plen;
    int       dlen;
    bit [7:0] v;
    r = $urandom_range(99);
    plen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(16);
    if (r < 80) begin
      case ($urandom_range(2))
        0: v = ATYP_IPV4;
        1: v = ATYP_DOMAIN;
        default: v = ATYP_IPV6;
      endcase
      dlen = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
      build_dgram(FRAG_NONE, v, dlen, plen);
      if (r >= 68) cut_dgram($urandom_range(dgram.size() - 1, 1));
    end else if (r < 87) begin
      build_dgram(8'($urandom_range(255, 1)), ATYP_IPV4, 0, plen);
    end else if (r < 94) begin
      do v = 8'($urandom_range(255));
      while (v == ATYP_IPV4 || v == ATYP_DOMAIN || v == ATYP_IPV6);
      build_dgram(FRAG_NONE, v, 0, plen);
    end else begin
      dgram.delete();
      repeat ($urandom_range(24, 1)) append_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic random_run(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(14) == 0) drain();
      random_dgram();
      send_dgram();
      sent += dgram.size();
    end
  endtask

  initial begin
    bit [7:0] bad_types[3];
    bad_types = '{8'h00, 8'h02, 8'hFF};
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Link is down after reset: every datagram ends as not connected.
    build_dgram(FRAG_NONE, ATYP_IPV4, 0, 2);
    send_dgram();
    dgram = '{8'h5A};
    send_dgram();

    write_reg(CFG_LINK_CONNECTED, 16'hFFFF);
    // Header that ends exactly on the final byte, extreme address and port bytes.
    build_dgram(FRAG_NONE, ATYP_IPV4, 0, 0);
    dgram[4] = 8'h00;
    dgram[7] = 8'hFF;
    dgram[8] = 8'hFF;
    dgram[9] = 8'hFF;
    send_dgram();
    build_dgram(FRAG_NONE, ATYP_IPV4, 0, 3);
    dgram[0] = 8'hFF;
    dgram[1] = 8'hFF;
    dgram[8] = 8'h00;
    dgram[9] = 8'h00;
    send_dgram();
    // Domain names: empty one goes straight to the port, then the longest.
    build_dgram(FRAG_NONE, ATYP_DOMAIN, 0, 3);
    send_dgram();
    build_dgram(FRAG_NONE, ATYP_DOMAIN, 255, 1);
    send_dgram();
    build_dgram(FRAG_NONE, ATYP_IPV6, 0, 2);
    send_dgram();
    // Fragmented and unknown address types.
    build_dgram(8'h80, ATYP_IPV4, 0, 6);
    send_dgram();
    foreach (bad_types[i]) begin
      build_dgram(FRAG_NONE, bad_types[i], 0, 6);
      send_dgram();
    end
    // Short datagrams, one of them with a fragment error underneath.
    build_dgram(FRAG_NONE, ATYP_DOMAIN, 0, 2);
    send_dgram();
    dgram = '{8'h00};
    send_dgram();
    build_dgram(8'h01, ATYP_IPV4, 0, 0);
    cut_dgram(5);
    send_dgram();
    // Truncated headers: after the address, and between the port bytes.
    build_dgram(FRAG_NONE, ATYP_IPV6, 0, 0);
    cut_dgram(20);
    send_dgram();
    build_dgram(FRAG_NONE, ATYP_DOMAIN, 4, 0);
    cut_dgram(10);
    send_dgram();
    // Buffer capacity at and near its lower end.
    write_reg(CFG_BUFFER_CAPACITY, 16'h0000);
    build_dgram(FRAG_NONE, ATYP_IPV4, 0, 5);
    send_dgram();
    write_reg(CFG_BUFFER_CAPACITY, 16'h0001);
    build_dgram(FRAG_NONE, ATYP_IPV4, 0, 5);
    send_dgram();

    // Random traffic under several settings.
    write_reg(CFG_BUFFER_CAPACITY, 16'hFFFF);
    random_run(340);
    write_reg(CFG_BUFFER_CAPACITY, 16'h0000);
    random_run(180);
    write_reg(CFG_BUFFER_CAPACITY, 16'h0001);
    random_run(180);
    write_reg(CFG_BUFFER_CAPACITY, 16'($urandom_range(8)));
    idle_on = 1'b0;
    random_run(300);
    idle_on = 1'b1;
    write_reg(CFG_LINK_CONNECTED, {15'($urandom_range(16'h7FFF)), 1'b0});
    random_run(100);
    write_reg(CFG_LINK_CONNECTED, {15'($urandom_range(16'h7FFF)), 1'b1});
    write_reg(CFG_BUFFER_CAPACITY, 16'($urandom_range(16'hFFFF)));
    random_run(300);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_recs.size() == 0) begin
      $display("socks5_udp_header_deframer: match");
    end else begin
      $display("socks5_udp_header_deframer: mismatch");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #16_000_000;
    $display("socks5_udp_header_deframer: mismatch");
    $finish;
  end

endmodule
